// ===== rtl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and microcode table for the tilt complementary filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int DW   = 36;           // internal datapath width
    localparam int CW   = 18;           // coefficient operand width, unsigned
    localparam int PW   = DW + CW + 1;  // full product width
    localparam int PC_W = 5;
    localparam int QF   = 16;           // fraction bits of Q0.16 coefficients

    localparam logic [PC_W-1:0] M1_START = PC_W'(6);
    localparam logic [PC_W-1:0] LAST_PC  = PC_W'(18);

    localparam logic [CW-1:0] ONE_Q16 = CW'(65536);

    localparam logic [15:0] BLEND_RST  = 16'd62747;
    localparam logic [15:0] PERIOD_RST = 16'd262;
    localparam logic [15:0] WEIGHT_RST = 16'd26214;
    localparam logic [15:0] GAIN_RST   = 16'd66;
    localparam logic [31:0] BIAS_RST   = 32'd13107;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_BLEND  = 3'd1,
        CFG_PERIOD = 3'd2,
        CFG_WEIGHT = 3'd3,
        CFG_GAIN   = 3'd4
    } cfg_idx_t;

    // multiplier signed operand
    typedef enum logic [2:0] {
        X_ACC, X_TMP, X_GYRO, X_ACCEL, X_OMK
    } xsel_t;

    // multiplier coefficient operand
    typedef enum logic [2:0] {
        C_DT, C_BLEND, C_OMB, C_GAIN, C_W2, C_TWO_OMK, C_OMK
    } csel_t;

    typedef enum logic [2:0] {
        A_ZERO, A_ANGLE, A_BIAS, A_INTEG, A_ACCEL, A_GYRO, A_ACC, A_TMP
    } asel_t;

    typedef enum logic [2:0] {
        B_ZERO, B_PROD, B_BIAS, B_ANGLE, B_INTEG, B_RATE
    } bsel_t;

    typedef enum logic [2:0] {
        D_NONE, D_ACC, D_TMP, D_ANGLE, D_BIAS, D_INTEG, D_RATE, D_W2
    } dst_t;

    typedef struct packed {
        logic  mul_en;
        xsel_t xsel;
        csel_t csel;
        asel_t asel;
        bsel_t bsel;
        logic  sub;
        logic  sat;
        dst_t  dst;
        logic  jmp_mode1;
        logic  last;
    } cw_t;

    typedef struct packed {
        logic load;     // input beat taken this cycle
        logic exec;     // current control word takes effect
        cw_t  cw;
    } seq_ctl_t;

    // Control store. PROD is the registered product shifted down by 16,
    // valid one step after the multiply is issued.
    function automatic cw_t ucode_rom(input logic [PC_W-1:0] pc);
        cw_t w;
        w = '{mul_en: 1'b0, xsel: X_ACC, csel: C_DT, asel: A_ZERO, bsel: B_ZERO,
              sub: 1'b0, sat: 1'b0, dst: D_NONE, jmp_mode1: 1'b0, last: 1'b0};
        case (pc)
            // dispatch on filter mode
            5'd0: w.jmp_mode1 = 1'b1;
            // first order
            5'd1: begin
                w.mul_en = 1'b1; w.xsel = X_GYRO; w.csel = C_DT;
                w.asel = A_GYRO; w.dst = D_RATE;
            end
            5'd2: begin
                w.asel = A_ANGLE; w.bsel = B_PROD; w.sat = 1'b1; w.dst = D_ACC;
            end
            5'd3: begin
                w.mul_en = 1'b1; w.xsel = X_ACC; w.csel = C_BLEND;
            end
            5'd4: begin
                w.mul_en = 1'b1; w.xsel = X_ACCEL; w.csel = C_OMB;
                w.bsel = B_PROD; w.dst = D_TMP;
            end
            5'd5: begin
                w.asel = A_TMP; w.bsel = B_PROD; w.sat = 1'b1; w.dst = D_ANGLE;
                w.last = 1'b1;
            end
            // second order
            5'd6: begin
                w.mul_en = 1'b1; w.xsel = X_OMK; w.csel = C_OMK;
                w.asel = A_GYRO; w.bsel = B_BIAS; w.sub = 1'b1; w.dst = D_ACC;
            end
            5'd7: begin
                w.mul_en = 1'b1; w.xsel = X_ACC; w.csel = C_GAIN;
                w.bsel = B_PROD; w.dst = D_W2;
            end
            5'd8: begin
                w.asel = A_BIAS; w.bsel = B_PROD; w.dst = D_BIAS;
            end
            5'd9: begin
                w.asel = A_GYRO; w.bsel = B_BIAS; w.sub = 1'b1; w.sat = 1'b1;
                w.dst = D_RATE;
            end
            5'd10: begin
                w.asel = A_ACCEL; w.bsel = B_ANGLE; w.sub = 1'b1; w.dst = D_ACC;
            end
            5'd11: begin
                w.mul_en = 1'b1; w.xsel = X_ACC; w.csel = C_W2;
            end
            5'd12: begin
                w.mul_en = 1'b1; w.xsel = X_ACC; w.csel = C_TWO_OMK;
                w.bsel = B_PROD; w.dst = D_TMP;
            end
            5'd13: begin
                w.mul_en = 1'b1; w.xsel = X_TMP; w.csel = C_DT;
                w.bsel = B_PROD; w.dst = D_ACC;
            end
            5'd14: begin
                w.asel = A_INTEG; w.bsel = B_PROD; w.sat = 1'b1; w.dst = D_INTEG;
            end
            5'd15: begin
                w.asel = A_ACC; w.bsel = B_INTEG; w.dst = D_ACC;
            end
            5'd16: begin
                w.asel = A_ACC; w.bsel = B_RATE; w.dst = D_ACC;
            end
            5'd17: begin
                w.mul_en = 1'b1; w.xsel = X_ACC; w.csel = C_DT;
            end
            5'd18: begin
                w.asel = A_ANGLE; w.bsel = B_PROD; w.sat = 1'b1; w.dst = D_ANGLE;
                w.last = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

    // clamp a DW+1 bit sum to the signed 32-bit range, sign-extended to DW
    function automatic logic signed [DW-1:0] sat32(input logic signed [DW:0] v);
        logic signed [DW-1:0] r;
        if (v[DW:31] == '0 || v[DW:31] == '1)
            r = v[DW-1:0];
        else if (v[DW])
            r = {{(DW-31){1'b1}}, 31'h0};
        else
            r = {{(DW-31){1'b0}}, 31'h7FFF_FFFF};
        return r;
    endfunction

endpackage

// ===== rtl/tcf_sequencer.sv =====
// ----------------------------------------------------------------------------
// tcf_sequencer
// Step counter over the control store, mode dispatch and result handshake.
// ----------------------------------------------------------------------------
module tcf_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                filter_mode,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tcf_pkg::seq_ctl_t   ctl
);
    import tcf_pkg::*;

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            ovalid_reg, ovalid_next;
    cw_t             cw;
    logic            load;
    logic            exec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pc_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            pc_reg     <= pc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        cw          = ucode_rom(pc_reg);
        load        = s_tvalid && !busy_reg;
        // the final step holds until the result register is free
        exec        = busy_reg && (!cw.last || !ovalid_reg || m_tready);
        busy_next   = busy_reg;
        pc_next     = pc_reg;
        ovalid_next = ovalid_reg && !m_tready;
        if (load)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (exec)
        begin
            if (cw.last)
            begin
                busy_next   = 1'b0;
                ovalid_next = 1'b1;
            end
            else if (cw.jmp_mode1 && filter_mode)
                pc_next = M1_START;
            else
                pc_next = pc_reg + PC_W'(1);
        end
    end

    assign s_tready = !busy_reg;
    assign m_tvalid = ovalid_reg;
    assign ctl      = '{load: load, exec: exec, cw: cw};

    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        exec && cw.last |=> ovalid_reg)
        else $error("finished step did not raise result valid");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= LAST_PC)
        else $error("step counter left the program");

    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> pc_reg == '0)
        else $error("program did not start at step zero");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !m_tready |=> !$past(exec && cw.last))
        else $error("result overwritten while still pending");

endmodule

// ===== rtl/tcf_datapath.sv =====
// ----------------------------------------------------------------------------
// tcf_datapath
// Shared multiplier, add/sub/saturate unit, filter state and result register.
// ----------------------------------------------------------------------------
module tcf_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tcf_pkg::seq_ctl_t   ctl,
    input  logic [15:0]         blend_coeff,
    input  logic [15:0]         sample_period,
    input  logic [15:0]         accel_weight,
    input  logic [15:0]         bias_gain,
    input  logic [31:0]         accel_angle,
    input  logic [31:0]         gyro_rate,
    output logic [31:0]         fused_angle,
    output logic [31:0]         corrected_rate
);
    import tcf_pkg::*;

    logic signed [31:0]   accel_reg;
    logic signed [31:0]   gyro_reg;
    logic signed [31:0]   angle_reg;
    logic signed [31:0]   bias_reg;
    logic signed [31:0]   integ_reg;
    logic signed [31:0]   rate_reg;
    logic        [CW-1:0] w2_reg;
    logic signed [DW-1:0] acc_reg;
    logic signed [DW-1:0] tmp_reg;
    logic signed [PW-1:0] prod_reg;
    logic        [31:0]   fused_reg;
    logic        [31:0]   orate_reg;

    logic        [CW-1:0] omk;
    logic        [CW-1:0] omb;
    logic signed [DW-1:0] x_op;
    logic        [CW-1:0] c_op;
    logic signed [PW-1:0] prod_next;
    logic signed [DW-1:0] prod_q;
    logic signed [DW-1:0] a_op;
    logic signed [DW-1:0] b_op;
    logic signed [DW:0]   sum;
    logic signed [DW-1:0] alu_res;

    function automatic logic signed [DW-1:0] sx(input logic [31:0] v);
        return {{(DW-32){v[31]}}, v};
    endfunction

    always_comb
    begin
        omk = ONE_Q16 - {2'b00, accel_weight};
        omb = ONE_Q16 - {2'b00, blend_coeff};

        case (ctl.cw.xsel)
            X_ACC:   x_op = acc_reg;
            X_TMP:   x_op = tmp_reg;
            X_GYRO:  x_op = sx(gyro_reg);
            X_ACCEL: x_op = sx(accel_reg);
            X_OMK:   x_op = {{(DW-CW){1'b0}}, omk};
            default: x_op = '0;
        endcase

        case (ctl.cw.csel)
            C_DT:      c_op = {2'b00, sample_period};
            C_BLEND:   c_op = {2'b00, blend_coeff};
            C_OMB:     c_op = omb;
            C_GAIN:    c_op = {2'b00, bias_gain};
            C_W2:      c_op = w2_reg;
            C_TWO_OMK: c_op = {omk[CW-2:0], 1'b0};
            C_OMK:     c_op = omk;
            default:   c_op = '0;
        endcase

        prod_next = PW'(x_op) * $signed({1'b0, c_op});
        // arithmetic shift: floor division by 2^16
        prod_q    = prod_reg[QF+DW-1:QF];

        case (ctl.cw.asel)
            A_ZERO:  a_op = '0;
            A_ANGLE: a_op = sx(angle_reg);
            A_BIAS:  a_op = sx(bias_reg);
            A_INTEG: a_op = sx(integ_reg);
            A_ACCEL: a_op = sx(accel_reg);
            A_GYRO:  a_op = sx(gyro_reg);
            A_ACC:   a_op = acc_reg;
            A_TMP:   a_op = tmp_reg;
            default: a_op = '0;
        endcase

        case (ctl.cw.bsel)
            B_ZERO:  b_op = '0;
            B_PROD:  b_op = prod_q;
            B_BIAS:  b_op = sx(bias_reg);
            B_ANGLE: b_op = sx(angle_reg);
            B_INTEG: b_op = sx(integ_reg);
            B_RATE:  b_op = sx(rate_reg);
            default: b_op = '0;
        endcase

        if (ctl.cw.sub)
            sum = {a_op[DW-1], a_op} - {b_op[DW-1], b_op};
        else
            sum = {a_op[DW-1], a_op} + {b_op[DW-1], b_op};
        alu_res = ctl.cw.sat ? sat32(sum) : sum[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            bias_reg  <= BIAS_RST;
            integ_reg <= '0;
        end
        else if (ctl.exec)
        begin
            case (ctl.cw.dst)
                D_ANGLE: angle_reg <= alu_res[31:0];
                D_BIAS:  bias_reg  <= alu_res[31:0];
                D_INTEG: integ_reg <= alu_res[31:0];
                default: ;
            endcase
        end
    end

    // scratch and payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            accel_reg <= accel_angle;
            gyro_reg  <= gyro_rate;
        end
        if (ctl.exec)
        begin
            if (ctl.cw.mul_en)
                prod_reg <= prod_next;
            case (ctl.cw.dst)
                D_ACC:   acc_reg  <= alu_res;
                D_TMP:   tmp_reg  <= alu_res;
                D_RATE:  rate_reg <= alu_res[31:0];
                D_W2:    w2_reg   <= alu_res[CW-1:0];
                default: ;
            endcase
            if (ctl.cw.last)
            begin
                fused_reg <= alu_res[31:0];
                orate_reg <= rate_reg;
            end
        end
    end

    assign fused_angle    = fused_reg;
    assign corrected_rate = orate_reg;

endmodule

// ===== rtl/tilt_complementary_filter_core.sv =====
// Sequence: a beat runs the dispatch step and then the first-order or the
//          second-order steps, one control-store step per cycle; the final step
//          stalls while a result is pending. Samples do not overlap: the single
//          shared 36x18 multiplier and the step sequence serve one sample at a time.
// Reset: filter state to angle 0, bias 0.2, integral 0; registers to defaults.
// ----------------------------------------------------------------------------
// tilt_complementary_filter_core
// Complementary tilt filter: microcoded sequencer over a shared multiplier.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] accel_angle, [63:32] gyro_rate
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] fused_angle, [63:32] corrected_rate
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import tcf_pkg::*;

    logic        mode_reg;
    logic [15:0] blend_reg;
    logic [15:0] period_reg;
    logic [15:0] weight_reg;
    logic [15:0] gain_reg;
    seq_ctl_t    ctl;
    logic [31:0] fused_angle;
    logic [31:0] corrected_rate;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            blend_reg  <= BLEND_RST;
            period_reg <= PERIOD_RST;
            weight_reg <= WEIGHT_RST;
            gain_reg   <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MODE:   mode_reg   <= cfg_wdata[0];
                CFG_BLEND:  blend_reg  <= cfg_wdata;
                CFG_PERIOD: period_reg <= cfg_wdata;
                CFG_WEIGHT: weight_reg <= cfg_wdata;
                CFG_GAIN:   gain_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tcf_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .filter_mode (mode_reg),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .ctl         (ctl)
    );

    tcf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .blend_coeff    (blend_reg),
        .sample_period  (period_reg),
        .accel_weight   (weight_reg),
        .bias_gain      (gain_reg),
        .accel_angle    (s_axis_tdata[31:0]),
        .gyro_rate      (s_axis_tdata[63:32]),
        .fused_angle    (fused_angle),
        .corrected_rate (corrected_rate)
    );

    assign m_axis_tdata = {corrected_rate, fused_angle};

endmodule

// ===== test/tilt_complementary_filter_core_tb.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter_core_tb
// Drives accel/gyro sample beats through the tilt filter under random
// backpressure and source gaps. Each sample is run through a local fixed-point
// filter model, and each result beat is compared field by field. A directed
// table covers range extremes, both filter modes, saturation, register masking
// and unused register indexes. Randomized phases with register changes follow.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcf_pkg::*;

    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         RANDOM_ITEMS   = 1800;
    localparam int         LONG_HOLD      = 400;
    localparam int         SETTLE         = 4;
    localparam int         DRAIN_CYCLES   = 40;
    localparam longint     UNITY_Q16      = 65536;
    localparam logic [2:0] CFG_UNUSED     = 3'd6;
    localparam longint     ACCEL_SPAN     = 5898240;    // +/-90 deg
    localparam longint     GYRO_SPAN      = 32768000;   // +/-500 deg/s

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  addr;
        logic [15:0] wdata;
        logic [31:0] accel;
        logic [31:0] gyro;
        bit          known;
        logic [31:0] fused;
        logic [31:0] rate;
    } row_t;

    typedef struct {
        logic [31:0] fused;
        logic [31:0] rate;
    } fusion_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // [31:0] accel_angle, [63:32] gyro_rate
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;     // [31:0] fused_angle, [63:32] corrected_rate
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    // filter model: registers and state
    bit          second_order;
    logic [15:0] blend_a;
    logic [15:0] dt_q16;
    logic [15:0] weight_k;
    logic [15:0] gain_b;
    longint      angle_est;
    longint      bias_est;
    longint      integ_est;

    fusion_t     pending_fusion[$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    bit          long_hold_req = 1'b0;

    tilt_complementary_filter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic longint clamp_s32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Q0.16 product, floor rounding
    function automatic longint scale_q16(input longint x, input longint c);
        return (x * c) >>> 16;
    endfunction

    function automatic fusion_t fuse_sample(input logic [31:0] accel_bits,
                                            input logic [31:0] gyro_bits);
        longint  accel;
        longint  gyro;
        longint  rate;
        longint  s;
        longint  omk;
        longint  w2;
        longint  err;
        longint  x1;
        longint  x2;
        fusion_t res;
        accel = longint'(signed'(accel_bits));
        gyro  = longint'(signed'(gyro_bits));
        if (!second_order)
        begin
            rate = gyro;
            s = clamp_s32(angle_est + scale_q16(rate, longint'(dt_q16)));
            angle_est = clamp_s32(scale_q16(s, longint'(blend_a)) +
                                  scale_q16(accel, UNITY_Q16 - longint'(blend_a)));
        end
        else
        begin
            omk = UNITY_Q16 - longint'(weight_k);
            w2  = (omk * omk) >>> 16;
            bias_est = bias_est + scale_q16(gyro - bias_est, longint'(gain_b));
            rate = clamp_s32(gyro - bias_est);
            err = accel - angle_est;
            x1 = scale_q16(err, w2);
            integ_est = clamp_s32(integ_est + scale_q16(x1, longint'(dt_q16)));
            x2 = integ_est + scale_q16(err, 2 * omk) + rate;
            angle_est = clamp_s32(angle_est + scale_q16(x2, longint'(dt_q16)));
        end
        res.fused = angle_est[31:0];
        res.rate  = rate[31:0];
        return res;
    endfunction

    function automatic row_t sample_row(input logic [31:0] a, input logic [31:0] g);
        row_t r;
        r = '{ROW_SAMPLE, 3'd0, 16'd0, a, g, 1'b0, 32'd0, 32'd0};
        return r;
    endfunction

    function automatic row_t known_row(input logic [31:0] a, input logic [31:0] g,
                                       input logic [31:0] f, input logic [31:0] rt);
        row_t r;
        r = '{ROW_SAMPLE, 3'd0, 16'd0, a, g, 1'b1, f, rt};
        return r;
    endfunction

    function automatic row_t write_row(input logic [2:0] addr, input logic [15:0] data);
        row_t r;
        r = '{ROW_WRITE, addr, data, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0};
        return r;
    endfunction

    function automatic logic [31:0] pick_value(input longint span);
        longint v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: v = 64'sd2147483647;
                    1: v = -64'sd2147483648;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            1, 2: v = longint'($urandom());
            default: v = longint'($urandom_range(0, 32'(2 * span))) - span;
        endcase
        return v[31:0];
    endfunction

    function automatic logic [15:0] pick_coeff(input logic [15:0] typical,
                                               input int unsigned cap);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1: return typical;
            default: return 16'($urandom_range(0, cap));
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            CFG_MODE:   second_order = data[0];
            CFG_BLEND:  blend_a  = data;
            CFG_PERIOD: dt_q16   = data;
            CFG_WEIGHT: weight_k = data;
            CFG_GAIN:   gain_b   = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [31:0] a, input logic [31:0] g,
                               input bit known, input logic [31:0] f,
                               input logic [31:0] rt);
        fusion_t res;
        int      gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {g, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = fuse_sample(a, g);
        if (known)
        begin
            res.fused = f;
            res.rate  = rt;
        end
        pending_fusion.push_back(res);
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and wait until every outstanding result has come back
    task automatic await_quiet();
        s_axis_tvalid <= 1'b0;
        while (pending_fusion.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        fusion_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_fusion.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_fusion.pop_front();
                if (m_axis_tdata[31:0] !== want.fused)
                begin
                    $display("%0t: fused_angle expected %h got %h",
                             $time, want.fused, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== want.rate)
                begin
                    $display("%0t: corrected_rate expected %h got %h",
                             $time, want.rate, m_axis_tdata[63:32]);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles without any beat or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("tilt_complementary_filter_core_tb: FAIL");
                $finish;
            end
        end
    end

    // result sink: random stalls after each beat, one long hold on request
    initial
    begin
        int hold;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    hold = LONG_HOLD;
                end
                else
                    hold = rx_idle ? $urandom_range(0, 16) : 0;
                if (hold > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (hold) @(posedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        row_t directed[$];
        int   sent;
        int   phase;
        int   n_items;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;

        second_order = 1'b0;
        blend_a   = BLEND_RST;
        dt_q16    = PERIOD_RST;
        weight_k  = WEIGHT_RST;
        gain_b    = GAIN_RST;
        angle_est = 0;
        bias_est  = longint'(BIAS_RST);
        integ_est = 0;

        directed = '{
            known_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
            sample_row(32'h0001_0000, 32'h0002_0000),
            sample_row(32'hFFFF_0000, 32'hFFFE_0000),
            // zero gyro weight: angle follows accel, rate passes through
            write_row(CFG_BLEND, 16'h0000),
            known_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
            known_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
            known_row(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001),
            // max weight and dt: drive the angle into saturation both ways
            write_row(CFG_BLEND, 16'hFFFF),
            write_row(CFG_PERIOD, 16'hFFFF),
            sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF),
            sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF),
            sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF),
            sample_row(32'h8000_0000, 32'h8000_0000),
            sample_row(32'h8000_0000, 32'h8000_0000),
            // mode takes bit 0 only
            write_row(CFG_MODE, 16'hFFFE),
            sample_row(32'h0000_0000, 32'h0001_2345),
            write_row(CFG_UNUSED, 16'hFFFF),
            sample_row(32'h0000_1000, 32'h0000_2000),
            // second order, frozen bias: rate clips low
            write_row(CFG_MODE, 16'h0001),
            write_row(CFG_GAIN, 16'h0000),
            write_row(CFG_WEIGHT, 16'h0000),
            sample_row(32'h0000_0000, 32'h8000_0000),
            sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF),
            sample_row(32'h8000_0000, 32'h8000_0000),
            write_row(CFG_GAIN, 16'hFFFF),
            write_row(CFG_WEIGHT, 16'hFFFF),
            write_row(CFG_PERIOD, 16'h0106),
            sample_row(32'h7FFF_FFFF, 32'h8000_0000),
            sample_row(32'h8000_0000, 32'h7FFF_FFFF),
            sample_row(32'h0001_0000, 32'h0000_0000)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_WRITE)
            begin
                await_quiet();
                write_reg(directed[i].addr, directed[i].wdata);
            end
            else
                send_sample(directed[i].accel, directed[i].gyro, directed[i].known,
                            directed[i].fused, directed[i].rate);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            await_quiet();
            write_reg(CFG_MODE, 16'($urandom_range(0, 65535)));
            write_reg(CFG_BLEND, pick_coeff(BLEND_RST, 65535));
            write_reg(CFG_PERIOD, pick_coeff(PERIOD_RST, 4000));
            write_reg(CFG_WEIGHT, pick_coeff(WEIGHT_RST, 65535));
            write_reg(CFG_GAIN, pick_coeff(GAIN_RST, 65535));
            if ($urandom_range(0, 3) == 0)
                write_reg(3'(CFG_GAIN) + 3'($urandom_range(1, 3)),
                          16'($urandom_range(0, 65535)));
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            // back-to-back source while the sink holds off
            if (phase == 1)
            begin
                tx_idle = 1'b0;
                long_hold_req = 1'b1;
            end
            n_items = $urandom_range(30, 150);
            repeat (n_items)
            begin
                send_sample(pick_value(ACCEL_SPAN), pick_value(GYRO_SPAN),
                            1'b0, 32'd0, 32'd0);
                sent++;
            end
            phase++;
        end

        await_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tilt_complementary_filter_core_tb: PASS");
        else
            $display("tilt_complementary_filter_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tcf_pkg.sv
rtl/tcf_sequencer.sv
rtl/tcf_datapath.sv
rtl/tilt_complementary_filter_core.sv
test/tilt_complementary_filter_core_tb.sv
